/* sv/cck_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cck_pkg: shared types and constants of the ChaCha20 keystream byte block
// Request/response payloads, mixing constants and the quarter-round half step.
// ----------------------------------------------------------------------------
package cck_pkg;

    // ChaCha20 "expand 32-byte k" constants
    localparam logic [31:0] CC_C0 = 32'h61707865;
    localparam logic [31:0] CC_C1 = 32'h3320646e;
    localparam logic [31:0] CC_C2 = 32'h79622d32;
    localparam logic [31:0] CC_C3 = 32'h6b206574;

    // splitmix64 constants and seed IV
    localparam logic [63:0] SM_GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MUL1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MUL2   = 64'h94d049bb133111eb;
    localparam logic [63:0] SEED_IV   = 64'h6a09e667f3bcc909;

    // seven splitmix64 words, one lane each
    localparam int N_LANE = 7;
    // 10 double rounds, each cut into four half steps of two adds
    localparam int N_HALF = 40;

    // State offsets k * golden for the parallel splitmix lanes, k = 1..7
    localparam logic [63:0] GOLD_MUL [N_LANE] = '{
        SM_GOLDEN * 64'd1, SM_GOLDEN * 64'd2, SM_GOLDEN * 64'd3,
        SM_GOLDEN * 64'd4, SM_GOLDEN * 64'd5, SM_GOLDEN * 64'd6,
        SM_GOLDEN * 64'd7
    };

    typedef logic [15:0][31:0] t_state;
    typedef logic [3:0][31:0]  t_quad;

    typedef struct packed {
        logic [63:0] function_key;
        logic [63:0] payload_seed;
        logic [63:0] chain_seed;
        logic [31:0] basic_block_offset;
        logic [31:0] byte_position;
    } t_req;

    typedef struct packed {
        logic [7:0] keystream_byte;
    } t_rsp;

    // Partial products of a 64x64 multiply mod 2^64
    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] lh;
        logic [31:0] hl;
    } t_pprod;

    // Half of a quarter round: a,b,c,d in q[0..3]; second half uses rot 8/7
    function automatic t_quad qr_half(input t_quad q, input logic second);
        logic [31:0] a, b, c, d;
        a = q[0];
        b = q[1];
        c = q[2];
        d = q[3];
        a = a + b;
        d = d ^ a;
        d = second ? {d[23:0], d[31:24]} : {d[15:0], d[31:16]};
        c = c + d;
        b = b ^ c;
        b = second ? {b[24:0], b[31:25]} : {b[19:0], b[31:20]};
        return {d, c, b, a};
    endfunction

endpackage
`default_nettype wire

/* sv/cck_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cck_if: valid/ready channels for keystream requests and responses
// A request moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface cck_req_if;
    logic          valid;
    logic          ready;
    cck_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cck_rsp_if;
    logic          valid;
    logic          ready;
    cck_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/chacha20_keystream_byte_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chacha20_keystream_byte_top: pipelined ChaCha20 keystream byte generator
// Seed mixing, seven parallel splitmix64 lanes and 20 ChaCha20 rounds.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                                            Width
// i_req     in   function_key, payload_seed, chain_seed,            64/64/64
//                basic_block_offset, byte_position                  32/32
// o_rsp     out  keystream_byte                                     8
//
// The pipeline holds 7 seed/splitmix stages, 40 round half-steps and 1 output.
// One request per cycle is accepted unless stalled; the rate is set by the
// single shared pipeline enable, high whenever the output register is free.
// A stalled output freezes every stage, so nothing is dropped or repeated.
// Synchronous active-low reset clears only the valid bits.
// ----------------------------------------------------------------------------
module chacha20_keystream_byte_top (
    input  wire              i_clk,
    input  wire              i_rst_n,
    cck_req_if.sink          i_req,
    cck_rsp_if.source        o_rsp
);

    localparam int NL = cck_pkg::N_LANE;
    localparam int NH = cck_pkg::N_HALF;

    logic en;

    // seed stages
    logic [6:0]  r_v;
    logic [63:0] r_s1_x;
    logic [63:0] r_s1_plo;
    logic [31:0] r_s1_phi;
    logic [63:0] r_s2_st;
    logic [63:0] r_s3_u [NL];
    cck_pkg::t_pprod r_s4_p [NL];
    logic [63:0] r_s5_w [NL];
    cck_pkg::t_pprod r_s6_p [NL];
    logic [63:0] r_s7_z [NL];
    logic [31:0] r_pos [7];

    logic [63:0] n_s1_x;
    logic [63:0] n_s2_st;
    logic [63:0] n_s3_u [NL];
    cck_pkg::t_pprod n_s4_p [NL];
    logic [63:0] n_s5_w [NL];
    cck_pkg::t_pprod n_s6_p [NL];
    logic [63:0] n_s7_z [NL];

    // round stages
    cck_pkg::t_state init_st;
    logic [31:0]     n_isel;
    cck_pkg::t_state r_work [NH];
    cck_pkg::t_state n_work [NH];
    logic [NH-1:0]   r_cv;
    logic [5:0]      r_sel  [NH];
    logic [31:0]     r_isel [NH];

    // output register
    logic        r_out_vld;
    logic [7:0]  r_out_byte;
    logic [31:0] fin_word;
    logic [31:0] fin_shift;

    // whole pipeline advances when the output register is free
    assign en          = !r_out_vld || o_rsp.ready;
    assign i_req.ready = en;

    // stage 1: rotate/xor mix and offset * golden partial products
    always_comb begin
        n_s1_x = i_req.data.function_key
               ^ {i_req.data.payload_seed[46:0], i_req.data.payload_seed[63:47]}
               ^ {i_req.data.chain_seed[34:0], i_req.data.chain_seed[63:35]}
               ^ cck_pkg::SEED_IV;
    end

    // stage 2: combine into the seed state
    always_comb begin
        n_s2_st = r_s1_x ^ (r_s1_plo + {r_s1_phi, 32'b0});
    end

    // stages 3..7: splitmix64 lanes
    always_comb begin
        logic [63:0] v;
        for (int k = 0; k < NL; k++) begin
            v         = r_s2_st + cck_pkg::GOLD_MUL[k];
            n_s3_u[k] = v ^ (v >> 30);
            n_s4_p[k].ll = r_s3_u[k][31:0] * cck_pkg::SM_MUL1[31:0];
            n_s4_p[k].lh = 32'(r_s3_u[k][31:0] * cck_pkg::SM_MUL1[63:32]);
            n_s4_p[k].hl = 32'(r_s3_u[k][63:32] * cck_pkg::SM_MUL1[31:0]);
            v         = r_s4_p[k].ll + {r_s4_p[k].lh + r_s4_p[k].hl, 32'b0};
            n_s5_w[k] = v ^ (v >> 27);
            n_s6_p[k].ll = r_s5_w[k][31:0] * cck_pkg::SM_MUL2[31:0];
            n_s6_p[k].lh = 32'(r_s5_w[k][31:0] * cck_pkg::SM_MUL2[63:32]);
            n_s6_p[k].hl = 32'(r_s5_w[k][63:32] * cck_pkg::SM_MUL2[31:0]);
            v         = r_s6_p[k].ll + {r_s6_p[k].lh + r_s6_p[k].hl, 32'b0};
            n_s7_z[k] = v ^ (v >> 31);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[5:0], i_req.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_x   <= n_s1_x;
            r_s1_plo <= i_req.data.basic_block_offset * cck_pkg::SM_GOLDEN[31:0];
            r_s1_phi <= 32'(i_req.data.basic_block_offset * cck_pkg::SM_GOLDEN[63:32]);
            r_s2_st  <= n_s2_st;
            r_pos[0] <= i_req.data.byte_position;
            for (int s = 1; s < 7; s++) begin
                r_pos[s] <= r_pos[s-1];
            end
            for (int k = 0; k < NL; k++) begin
                r_s3_u[k] <= n_s3_u[k];
                r_s4_p[k] <= n_s4_p[k];
                r_s5_w[k] <= n_s5_w[k];
                r_s6_p[k] <= n_s6_p[k];
                r_s7_z[k] <= n_s7_z[k];
            end
        end
    end

    // initial ChaCha20 state and the input word the final add needs
    always_comb begin
        init_st[0]  = cck_pkg::CC_C0;
        init_st[1]  = cck_pkg::CC_C1;
        init_st[2]  = cck_pkg::CC_C2;
        init_st[3]  = cck_pkg::CC_C3;
        for (int k = 0; k < 4; k++) begin
            init_st[4 + 2*k] = r_s7_z[k][31:0];
            init_st[5 + 2*k] = r_s7_z[k][63:32];
        end
        init_st[12] = {6'b0, r_pos[6][31:6]};
        init_st[13] = r_s7_z[4][31:0];
        init_st[14] = r_s7_z[5][31:0];
        init_st[15] = r_s7_z[6][31:0];
        n_isel      = init_st[r_pos[6][5:2]];
    end

    // round half steps: column rounds on even rounds, diagonal on odd
    for (genvar h = 0; h < NH; h++) begin : g_half
        localparam int  SH  = (h / 2) % 2;
        localparam logic SEC = (h % 2) == 1;
        cck_pkg::t_state src;
        cck_pkg::t_quad  q;

        always_comb begin
            src = (h == 0) ? init_st : r_work[(h == 0) ? 0 : h - 1];
            n_work[h] = src;
            for (int i = 0; i < 4; i++) begin
                q = {src[12 + ((i + 3*SH) & 3)], src[8 + ((i + 2*SH) & 3)],
                     src[4 + ((i + SH) & 3)], src[i]};
                q = cck_pkg::qr_half(q, SEC);
                n_work[h][i]                    = q[0];
                n_work[h][4 + ((i + SH) & 3)]   = q[1];
                n_work[h][8 + ((i + 2*SH) & 3)] = q[2];
                n_work[h][12 + ((i + 3*SH) & 3)] = q[3];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_work[h] <= n_work[h];
                if (h == 0) begin
                    r_sel[h]  <= r_pos[6][5:0];
                    r_isel[h] <= n_isel;
                end else begin
                    r_sel[h]  <= r_sel[(h == 0) ? 0 : h - 1];
                    r_isel[h] <= r_isel[(h == 0) ? 0 : h - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= '0;
        end else if (en) begin
            r_cv <= {r_cv[NH-2:0], r_v[6]};
        end
    end

    // feed-forward add and little-endian byte pick
    always_comb begin
        fin_word  = r_work[NH-1][r_sel[NH-1][5:2]] + r_isel[NH-1];
        fin_shift = fin_word >> {r_sel[NH-1][1:0], 3'b000};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_cv[NH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_byte <= fin_shift[7:0];
        end
    end

    assign o_rsp.valid               = r_out_vld;
    assign o_rsp.data.keystream_byte = r_out_byte;

    // checks
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !r_out_vld)
        else $error("output valid not cleared by reset");
    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_cv[NH-1] |=> r_out_vld)
        else $error("request lost between last round and output");
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_cv) && $stable(r_v))
        else $error("pipeline moved during a stall");
    a_backpress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_rsp.ready |-> !i_req.ready)
        else $error("request taken while output is blocked");

endmodule
`default_nettype wire

/* tb/tb_chacha20_keystream_byte_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chacha20_keystream_byte_top: checks the ChaCha20 keystream byte pipeline
// Requests with directed and random seeds go in through a driver with random
// gaps. Each response is compared with a byte computed by an in-bench
// ChaCha20 block with splitmix64 key setup. The response side stalls at random.
// ----------------------------------------------------------------------------
module tb_chacha20_keystream_byte_top;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cck_req_if req_ch ();
    cck_rsp_if rsp_ch ();

    chacha20_keystream_byte_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always #2 i_clk = ~i_clk;

    cck_pkg::t_req pending_reqs[$];
    logic [7:0]    expected_bytes[$];
    int            n_errors = 0;
    bit            stim_done = 1'b0;
    int            req_gap = 0;
    int            rsp_gap = 0;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [63:0] mix64(inout logic [63:0] st);
        logic [63:0] v;
        st = st + cck_pkg::SM_GOLDEN;
        v = st;
        v = v ^ (v >> 30);
        v = v * cck_pkg::SM_MUL1;
        v = v ^ (v >> 27);
        v = v * cck_pkg::SM_MUL2;
        v = v ^ (v >> 31);
        return v;
    endfunction

    function automatic void qround(inout logic [31:0] x[16], input int a, input int b,
                                   input int c, input int d);
        x[a] = x[a] + x[b]; x[d] = rotl32(x[d] ^ x[a], 16);
        x[c] = x[c] + x[d]; x[b] = rotl32(x[b] ^ x[c], 12);
        x[a] = x[a] + x[b]; x[d] = rotl32(x[d] ^ x[a], 8);
        x[c] = x[c] + x[d]; x[b] = rotl32(x[b] ^ x[c], 7);
    endfunction

    // Keystream byte for one request
    function automatic logic [7:0] keystream_byte_of(input cck_pkg::t_req r);
        logic [63:0] st, w;
        logic [31:0] init[16];
        logic [31:0] x[16];
        logic [31:0] word;
        logic [5:0]  sel;
        st = r.function_key ^ {r.payload_seed[46:0], r.payload_seed[63:47]}
             ^ {r.chain_seed[34:0], r.chain_seed[63:35]}
             ^ (64'(r.basic_block_offset) * cck_pkg::SM_GOLDEN) ^ cck_pkg::SEED_IV;
        init[0] = cck_pkg::CC_C0; init[1] = cck_pkg::CC_C1;
        init[2] = cck_pkg::CC_C2; init[3] = cck_pkg::CC_C3;
        for (int i = 0; i < 4; i++) begin
            w = mix64(st);
            init[4 + 2 * i] = w[31:0];
            init[5 + 2 * i] = w[63:32];
        end
        init[12] = r.byte_position >> 6;
        for (int i = 0; i < 3; i++) begin
            w = mix64(st);
            init[13 + i] = w[31:0];
        end
        x = init;
        for (int i = 0; i < 10; i++) begin
            qround(x, 0, 4, 8, 12); qround(x, 1, 5, 9, 13);
            qround(x, 2, 6, 10, 14); qround(x, 3, 7, 11, 15);
            qround(x, 0, 5, 10, 15); qround(x, 1, 6, 11, 12);
            qround(x, 2, 7, 8, 13); qround(x, 3, 4, 9, 14);
        end
        sel = r.byte_position[5:0];
        word = x[sel[5:2]] + init[sel[5:2]];
        return word[8 * sel[1:0] +: 8];
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        n_errors++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly short gaps, a few long ones, often none
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (req_ch.valid) expected_bytes.push_back(keystream_byte_of(req_ch.data));
            if (req_gap > 0) begin
                req_gap <= req_gap - 1;
                req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                req_ch.data  <= pending_reqs.pop_front();
                req_ch.valid <= 1'b1;
                req_gap <= pick_gap();
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Response monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected response %02h",
                                              rsp_ch.data.keystream_byte));
                end else begin
                    logic [7:0] exp_byte;
                    exp_byte = expected_bytes.pop_front();
                    if (rsp_ch.data.keystream_byte !== exp_byte)
                        report_mismatch($sformatf("keystream_byte %02h, expected %02h",
                                                  rsp_ch.data.keystream_byte, exp_byte));
                end
            end
            if (rsp_gap > 0) begin
                rsp_gap <= rsp_gap - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                rsp_gap <= pick_gap();
            end
        end
    end

    function automatic cck_pkg::t_req rand_req();
        cck_pkg::t_req r;
        r.function_key       = rand64();
        r.payload_seed       = rand64();
        r.chain_seed         = rand64();
        r.basic_block_offset = $urandom();
        r.byte_position      = $urandom();
        return r;
    endfunction

    initial begin
        cck_pkg::t_req r;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        // Directed: zero key material, all ones, every byte lane, counter extremes
        pending_reqs.push_back('0);
        pending_reqs.push_back('1);
        for (int i = 0; i < 4; i++) begin
            r = '0;
            r.byte_position = i;
            pending_reqs.push_back(r);
        end
        r = '0; r.byte_position = 32'd63; pending_reqs.push_back(r);
        r = '0; r.byte_position = 32'd64; pending_reqs.push_back(r);
        r = '0; r.byte_position = 32'hFFFF_FFC0; pending_reqs.push_back(r);
        r = '0; r.basic_block_offset = 32'hFFFF_FFFF; pending_reqs.push_back(r);
        r = '0; r.function_key = '1; pending_reqs.push_back(r);
        r = '0; r.payload_seed = 64'h1; pending_reqs.push_back(r);
        r = '0; r.chain_seed = 64'h8000_0000_0000_0000; pending_reqs.push_back(r);
        for (int i = 0; i < 8; i++) begin
            r = rand_req();
            r.byte_position[5:0] = 6'(i * 9);
            pending_reqs.push_back(r);
        end
        // Random: the same seeds across a run of positions now and then
        while (pending_reqs.size() < 1350) begin
            r = rand_req();
            if ($urandom_range(0, 3) == 0) begin
                for (int k = 0; k < 8; k++) begin
                    r.byte_position = r.byte_position + 1;
                    pending_reqs.push_back(r);
                end
            end else begin
                pending_reqs.push_back(r);
            end
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && !req_ch.valid);
        wait (expected_bytes.size() == 0);
        repeat (100) @(posedge i_clk);
        if (n_errors == 0 && expected_bytes.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

/* files.f */
sv/cck_pkg.sv
sv/cck_if.sv
sv/chacha20_keystream_byte_top.sv
tb/tb_chacha20_keystream_byte_top.sv
